// ===== hdl/source_text_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define STT_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define STT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/stt_pkg.sv =====
// Types, token codes, character codes and helper functions of the tokenizer.
// No dependencies; used by every other file of the block but the assertion header.
package stt_pkg;

  typedef logic [4:0] tok_t;
  typedef logic [1:0] wcls_t;

  // Token codes
  localparam tok_t TT_WORD    = 5'd0;
  localparam tok_t TT_NEWLINE = 5'd1;
  localparam tok_t TT_ASSIGN  = 5'd2;
  localparam tok_t TT_COLON   = 5'd3;
  localparam tok_t TT_LPAREN  = 5'd4;
  localparam tok_t TT_RPAREN  = 5'd5;
  localparam tok_t TT_COMMA   = 5'd6;
  localparam tok_t TT_SEMI    = 5'd7;
  localparam tok_t TT_RANGE   = 5'd8;
  localparam tok_t TT_DOT     = 5'd9;
  localparam tok_t TT_LBRACK  = 5'd10;
  localparam tok_t TT_RBRACK  = 5'd11;
  localparam tok_t TT_ARROW   = 5'd12;
  localparam tok_t TT_EQ      = 5'd13;
  localparam tok_t TT_NEQ     = 5'd14;
  localparam tok_t TT_SLASH   = 5'd15;
  localparam tok_t TT_LE      = 5'd16;
  localparam tok_t TT_LT      = 5'd17;
  localparam tok_t TT_GE      = 5'd18;
  localparam tok_t TT_GT      = 5'd19;
  localparam tok_t TT_PLUS    = 5'd20;
  localparam tok_t TT_MINUS   = 5'd21;
  localparam tok_t TT_STAR    = 5'd22;
  localparam tok_t TT_PERCENT = 5'd23;
  localparam tok_t TT_BADCHAR = 5'd24;
  localparam tok_t TT_TOOLONG = 5'd25;

  // Word classes
  localparam wcls_t WC_IDENT   = 2'd0;
  localparam wcls_t WC_INTEGER = 2'd1;
  localparam wcls_t WC_REAL    = 2'd2;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Depth of the result queue
  localparam int RES_DEPTH = 4;

  // One result item
  typedef struct packed {
    tok_t        token_type;
    wcls_t       word_class;
    logic [15:0] line_number;
    logic [15:0] column;
    logic [23:0] text_offset;
    logic [6:0]  token_length;
    logic        last_of_run;
  } res_t;

  // Results of one processed item, handed to the queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Operator lookup result
  typedef struct packed {
    logic hit;
    logic two;
    tok_t code;
  } op_t;

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic res_t mk_res(input tok_t ty, input wcls_t cls,
                                  input logic [15:0] ln, input logic [15:0] col,
                                  input logic [23:0] off, input logic [6:0] len);
    res_t r;
    r.token_type   = ty;
    r.word_class   = cls;
    r.line_number  = ln;
    r.column       = col;
    r.text_offset  = off;
    r.token_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Operator code for c with one byte of lookahead n
  function automatic op_t op_code(input logic [7:0] c, input logic [7:0] n);
    op_t o;
    o.hit  = 1'b1;
    o.two  = 1'b0;
    o.code = TT_WORD;
    case (c)
      CH_COLON: begin
        o.two  = (n == CH_EQ);
        o.code = o.two ? TT_ASSIGN : TT_COLON;
      end
      CH_LPAR:  o.code = TT_LPAREN;
      CH_RPAR:  o.code = TT_RPAREN;
      CH_COMMA: o.code = TT_COMMA;
      CH_SEMI:  o.code = TT_SEMI;
      CH_DOT: begin
        o.two  = (n == CH_DOT);
        o.code = o.two ? TT_RANGE : TT_DOT;
      end
      CH_LBRK:  o.code = TT_LBRACK;
      CH_RBRK:  o.code = TT_RBRACK;
      CH_EQ: begin
        o.two  = (n == CH_GT);
        o.code = o.two ? TT_ARROW : TT_EQ;
      end
      CH_SLASH: begin
        o.two  = (n == CH_EQ);
        o.code = o.two ? TT_NEQ : TT_SLASH;
      end
      CH_LT: begin
        o.two  = (n == CH_EQ);
        o.code = o.two ? TT_LE : TT_LT;
      end
      CH_GT: begin
        o.two  = (n == CH_EQ);
        o.code = o.two ? TT_GE : TT_GT;
      end
      CH_PLUS:  o.code = TT_PLUS;
      CH_MINUS: o.code = TT_MINUS;
      CH_STAR:  o.code = TT_STAR;
      CH_PCT:   o.code = TT_PERCENT;
      default:  o.hit  = 1'b0;
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/stt_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on stt_pkg for the token field types.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic [7:0] next_ch;
  logic       is_last;

  modport source (output valid, output ch, output next_ch, output is_last, input ready);
  modport sink   (input valid, input ch, input next_ch, input is_last, output ready);
endinterface

interface stt_out_if;
  logic                valid;
  logic                ready;
  stt_pkg::tok_t       token_type;
  stt_pkg::wcls_t      word_class;
  logic [15:0]         line_number;
  logic [15:0]         column;
  logic [23:0]         text_offset;
  logic [6:0]          token_length;
  logic                last_of_run;

  modport source (output valid, output token_type, output word_class, output line_number,
                  output column, output text_offset, output token_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_type, input word_class, input line_number,
                  input column, input text_offset, input token_length,
                  input last_of_run, output ready);
endinterface

// ===== hdl/stt_core.sv =====
// Tokenizer core: input register, scan state and the per-byte decode.
// Depends on stt_pkg, stt_if and source_text_tokenizer_assert.svh.
`include "source_text_tokenizer_assert.svh"

module stt_core #(
  parameter int WORD_BUFFER_BYTES = 128,
  parameter int OFFSET_BITS       = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  stt_in_if.sink          in_chan,
  input  logic            room,
  output stt_pkg::push_t  push
);

  localparam int LEN_W = $clog2(WORD_BUFFER_BYTES);

  // Input register
  logic       in_valid_r;
  logic [7:0] ch_r;
  logic [7:0] nx_r;
  logic       last_r;
  logic       fire;

  // Scan state
  logic [15:0]            line_r,  line_nxt;
  logic [15:0]            colc_r,  colc_nxt;
  logic [OFFSET_BITS-1:0] boff_r,  boff_nxt;
  logic [LEN_W-1:0]       wlen_r,  wlen_nxt;
  logic [15:0]            wcol_r,  wcol_nxt;
  logic [OFFSET_BITS-1:0] woff_r,  woff_nxt;
  logic                   id_r,    id_nxt;
  logic                   int_r,   int_nxt;
  logic                   real_r,  real_nxt;
  logic                   cmt_r,   cmt_nxt;
  logic                   skip_r,  skip_nxt;
  logic                   halt_r,  halt_nxt;

  // Candidate results in emission order: flushed word, main token, final flush
  logic            f_v, m_v, l_v;
  stt_pkg::res_t   f_res, m_res, l_res;

  assign fire          = in_valid_r && room;
  assign in_chan.ready = !in_valid_r || fire;

  // Input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
    if (in_chan.valid && in_chan.ready) begin
      ch_r   <= in_chan.ch;
      nx_r   <= in_chan.next_ch;
      last_r <= in_chan.is_last;
    end
  end

  // Byte decode and state update
  always_comb begin
    logic [15:0]            col;
    logic [OFFSET_BITS-1:0] off;
    logic                   wo;
    logic                   is_ws;
    logic                   is_letter;
    logic                   is_digit;
    logic                   ovf;
    logic [LEN_W-1:0]       len_eff;
    logic [15:0]            scol_eff;
    logic [OFFSET_BITS-1:0] soff_eff;
    stt_pkg::wcls_t         cls;
    stt_pkg::op_t           op;

    line_nxt = line_r;
    colc_nxt = colc_r;
    boff_nxt = boff_r;
    wlen_nxt = wlen_r;
    wcol_nxt = wcol_r;
    woff_nxt = woff_r;
    id_nxt   = id_r;
    int_nxt  = int_r;
    real_nxt = real_r;
    cmt_nxt  = cmt_r;
    skip_nxt = skip_r;
    halt_nxt = halt_r;
    f_v = 1'b0;
    m_v = 1'b0;
    l_v = 1'b0;

    col       = stt_pkg::sat16_inc(colc_r);
    off       = boff_r;
    wo        = id_r || int_r || real_r;
    is_ws     = ch_r inside {stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR,
                             stt_pkg::CH_LF};
    is_letter = ch_r inside {[8'h61:8'h7A], [8'h41:8'h5A], stt_pkg::CH_UNDER};
    is_digit  = ch_r inside {[8'h30:8'h39]};
    len_eff   = wo ? wlen_r : '0;
    scol_eff  = wo ? wcol_r : col;
    soff_eff  = wo ? woff_r : off;
    ovf       = len_eff >= LEN_W'(WORD_BUFFER_BYTES - 1);
    cls       = real_r ? stt_pkg::WC_REAL : (int_r ? stt_pkg::WC_INTEGER : stt_pkg::WC_IDENT);
    op        = stt_pkg::op_code(ch_r, nx_r);

    f_res = stt_pkg::mk_res(stt_pkg::TT_WORD, cls, line_r, wcol_r, 24'(woff_r), 7'(wlen_r));
    m_res = stt_pkg::mk_res(stt_pkg::TT_NEWLINE, stt_pkg::WC_IDENT, line_r, col, 24'(off),
                            7'd1);

    if (!halt_r) begin
      colc_nxt = col;
      boff_nxt = off + OFFSET_BITS'(1);

      if (skip_r) begin
        // second byte of a pair
        skip_nxt = 1'b0;
      end else if (cmt_r) begin
        if (ch_r == stt_pkg::CH_LF) begin
          m_v      = 1'b1;
          cmt_nxt  = 1'b0;
          line_nxt = stt_pkg::sat16_inc(line_r);
          colc_nxt = '0;
        end
      end else if (is_ws) begin
        if (wo) begin
          f_v      = 1'b1;
          wlen_nxt = '0;
          id_nxt   = 1'b0;
          int_nxt  = 1'b0;
          real_nxt = 1'b0;
        end
        if (ch_r == stt_pkg::CH_LF) begin
          m_v      = 1'b1;
          line_nxt = stt_pkg::sat16_inc(line_r);
          colc_nxt = '0;
        end
      end else if (is_letter || is_digit ||
                   (ch_r == stt_pkg::CH_DOT && nx_r != stt_pkg::CH_DOT && int_r)) begin
        // byte joins the word
        wcol_nxt = scol_eff;
        woff_nxt = soff_eff;
        if (is_letter) begin
          id_nxt   = 1'b1;
          int_nxt  = 1'b0;
          real_nxt = 1'b0;
        end else if (is_digit) begin
          if (!wo) int_nxt = 1'b1;
        end
        if (ovf) begin
          m_v      = 1'b1;
          m_res    = stt_pkg::mk_res(stt_pkg::TT_TOOLONG, stt_pkg::WC_IDENT, line_r, scol_eff,
                                     24'(soff_eff), 7'(len_eff));
          wlen_nxt = len_eff;
          halt_nxt = 1'b1;
        end else begin
          wlen_nxt = len_eff + LEN_W'(1);
          if (!is_letter && !is_digit) begin
            int_nxt  = 1'b0;
            real_nxt = 1'b1;
          end
        end
      end else begin
        // operator, comment opener or bad byte; a pending word goes first
        if (wo) begin
          f_v      = 1'b1;
          wlen_nxt = '0;
          id_nxt   = 1'b0;
          int_nxt  = 1'b0;
          real_nxt = 1'b0;
        end
        if (ch_r == stt_pkg::CH_SLASH && nx_r == stt_pkg::CH_SLASH) begin
          cmt_nxt = 1'b1;
        end else if (op.hit) begin
          m_v      = 1'b1;
          m_res    = stt_pkg::mk_res(op.code, stt_pkg::WC_IDENT, line_r, col, 24'(off),
                                     op.two ? 7'd2 : 7'd1);
          skip_nxt = op.two;
        end else begin
          m_v      = 1'b1;
          m_res    = stt_pkg::mk_res(stt_pkg::TT_BADCHAR, stt_pkg::WC_IDENT, line_r, col,
                                     24'(off), 7'd1);
          halt_nxt = 1'b1;
        end
      end

      // end of text flushes a word still open
      l_res = stt_pkg::mk_res(stt_pkg::TT_WORD,
                              real_nxt ? stt_pkg::WC_REAL :
                              (int_nxt ? stt_pkg::WC_INTEGER : stt_pkg::WC_IDENT),
                              line_nxt, wcol_nxt, 24'(woff_nxt), 7'(wlen_nxt));
      if (last_r && !halt_nxt && (id_nxt || int_nxt || real_nxt)) begin
        l_v      = 1'b1;
        wlen_nxt = '0;
        id_nxt   = 1'b0;
        int_nxt  = 1'b0;
        real_nxt = 1'b0;
      end
    end else begin
      l_res = f_res;
    end
  end

  // Pack up to two results for the queue
  always_comb begin
    push.r0 = l_res;
    push.r1 = l_res;
    if (f_v) begin
      push.r0 = f_res;
      push.r1 = m_v ? m_res : l_res;
      push.n  = (m_v || l_v) ? 2'd2 : 2'd1;
    end else if (m_v) begin
      push.r0 = m_res;
      push.n  = l_v ? 2'd2 : 2'd1;
    end else begin
      push.n  = l_v ? 2'd1 : 2'd0;
    end
    push.r0.last_of_run = (push.n == 2'd1);
    push.r1.last_of_run = 1'b1;
    if (!fire) push.n = 2'd0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 16'd1;
      colc_r <= '0;
      boff_r <= '0;
      wlen_r <= '0;
      wcol_r <= '0;
      woff_r <= '0;
      id_r   <= 1'b0;
      int_r  <= 1'b0;
      real_r <= 1'b0;
      cmt_r  <= 1'b0;
      skip_r <= 1'b0;
      halt_r <= 1'b0;
    end else if (fire) begin
      line_r <= line_nxt;
      colc_r <= colc_nxt;
      boff_r <= boff_nxt;
      wlen_r <= wlen_nxt;
      wcol_r <= wcol_nxt;
      woff_r <= woff_nxt;
      id_r   <= id_nxt;
      int_r  <= int_nxt;
      real_r <= real_nxt;
      cmt_r  <= cmt_nxt;
      skip_r <= skip_nxt;
      halt_r <= halt_nxt;
    end
  end

  // Checks
  `STT_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r, "halt released without reset")
  `STT_ASSERT(a_halt_quiet, halt_r, push.n == 2'd0, "result pushed while halted")
  `STT_ASSERT(a_word_class, 1'b1, $onehot0({id_r, int_r, real_r}), "word flags overlap")
  `STT_ASSERT(a_mode_excl, 1'b1, !(cmt_r && skip_r), "comment and skip both set")

endmodule

// ===== hdl/stt_res_fifo.sv =====
// Four-entry result queue between the decode and the token channel.
// Depends on stt_pkg, stt_if and source_text_tokenizer_assert.svh.
`include "source_text_tokenizer_assert.svh"

module stt_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  stt_pkg::push_t  push,
  output logic            room,
  stt_out_if.source       out_chan
);

  localparam int PTR_W = $clog2(stt_pkg::RES_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  stt_pkg::res_t    q_r [stt_pkg::RES_DEPTH];
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] cnt_pop;
  logic             pop;
  logic [PTR_W-1:0] tail_p1;
  stt_pkg::res_t    head_item;

  assign pop     = out_chan.valid && out_chan.ready;
  assign cnt_pop = count_r - CNT_W'(pop);
  // room for a two-result item after this cycle's pop
  assign room    = cnt_pop <= CNT_W'(stt_pkg::RES_DEPTH - 2);
  assign tail_p1 = tail_r + PTR_W'(1);

  // Queue storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[tail_r] <= push.r0;
    if (push.n == 2'd2) q_r[tail_p1] <= push.r1;
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_r + PTR_W'(pop);
      tail_r  <= tail_r + PTR_W'(push.n);
      count_r <= cnt_pop + CNT_W'(push.n);
    end
  end

  // Head item drives the channel
  assign head_item             = q_r[head_r];
  assign out_chan.valid        = count_r != '0;
  assign out_chan.token_type   = head_item.token_type;
  assign out_chan.word_class   = head_item.word_class;
  assign out_chan.line_number  = head_item.line_number;
  assign out_chan.column       = head_item.column;
  assign out_chan.text_offset  = head_item.text_offset;
  assign out_chan.token_length = head_item.token_length;
  assign out_chan.last_of_run  = head_item.last_of_run;

  // Checks
  `STT_ASSERT(a_fill_bound, 1'b1, count_r <= CNT_W'(stt_pkg::RES_DEPTH), "queue overfull")
  `STT_ASSERT(a_no_overflow, push.n != 2'd0,
              ({1'b0, cnt_pop} + (CNT_W + 1)'(push.n)) <= (CNT_W + 1)'(stt_pkg::RES_DEPTH),
              "push into full queue")

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: decode core plus result queue.
// Depends on stt_pkg, stt_if, stt_core and stt_res_fifo.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    ch, next_ch, is_last
//   out_chan  out  valid/ready    token_type, word_class, line_number, column,
//                                 text_offset, token_length, last_of_run
//
// One byte is accepted per cycle while the result queue has room; its tokens are
// written into the queue when the byte is decoded and leave it in order, one token
// per cycle while out_chan.ready is high.
// The input register stalls while the four-entry result queue lacks two free
// slots. Reset is synchronous, active low; a halted tokenizer still accepts
// bytes and drops them until reset.
module source_text_tokenizer #(
  parameter int WORD_BUFFER_BYTES = 128,
  parameter int OFFSET_BITS       = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);

  stt_pkg::push_t push;
  logic           room;

  stt_core #(
    .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  stt_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule
